### design/angular_zigzag_sweep_generator_core_macros.svh
// Assertion helpers for the sweep generator.
`ifndef ANGULAR_ZIGZAG_SWEEP_GENERATOR_CORE_MACROS_SVH
`define ANGULAR_ZIGZAG_SWEEP_GENERATOR_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define AZSG_ASSERT_SAME(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sweep generator check failed");

// next-cycle implication, sampled on clk, off during reset
`define AZSG_ASSERT_NEXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sweep generator check failed");

`endif

### design/azsg_pkg.sv
package azsg_pkg;

	// register map
	localparam int REG_COUNT = 8;
	localparam int REG_IDX_W = 3;
	localparam int PADDR_W   = 5;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_MIN_ANGLE     = 3'd0,
		REG_MAX_ANGLE     = 3'd1,
		REG_MIN_EXTENSION = 3'd2,
		REG_SETTLE_TICKS  = 3'd3,
		REG_CYCLE_LENGTH  = 3'd4,
		REG_SHRINK_STEP   = 3'd5,
		REG_ROW_STEP      = 3'd6,
		REG_ANGLE_STEP    = 3'd7
	} reg_idx_t;

	// input opcodes
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_START = 1'b1;

	// reset values
	localparam logic signed [15:0] MIN_ANGLE_RST     = 16'sd0;
	localparam logic signed [15:0] MAX_ANGLE_RST     = 16'sd12868;
	localparam logic        [15:0] MIN_EXTENSION_RST = 16'd6554;
	localparam logic        [15:0] SETTLE_TICKS_RST  = 16'd0;
	localparam logic        [15:0] CYCLE_LENGTH_RST  = 16'd1;
	localparam logic        [15:0] SHRINK_STEP_RST   = 16'd66;
	localparam logic        [15:0] ROW_STEP_RST      = 16'd655;
	localparam logic        [14:0] ANGLE_STEP_RST    = 15'd41;

	// remainder unit: 17-bit dividend, one bit per cycle
	localparam int REM_STEPS = 17;
	localparam int REM_CNT_W = 5;

	typedef struct packed {
		logic                op;
		logic signed [15:0]  start_angle;
		logic        [15:0]  start_extension;
		logic                start_clockwise;
	} item_t;

	typedef struct packed {
		logic signed [15:0]  angle_command;
		logic        [15:0]  ext_cmd;
		logic                hold_flag;
		logic                running;
	} result_t;

	typedef struct packed {
		logic signed [15:0]  min_angle;
		logic signed [15:0]  max_angle;
		logic        [15:0]  min_extension;
		logic        [15:0]  settle_ticks;
		logic        [15:0]  cycle_length;
		logic        [15:0]  shrink_step;
		logic        [15:0]  row_step;
		logic        [14:0]  angle_step;
	} cfg_t;

	// cycle-length write events seen by the core
	typedef struct packed {
		logic wr_len;    // write to cycle_length at this edge
		logic len_pend;  // write happened last edge, reduction not yet started
	} cfg_evt_t;

	// remainder unit status
	typedef struct packed {
		logic        busy;
		logic        done;
		logic [15:0] value;
	} rem_stat_t;

	// zero length acts as one
	function automatic logic [15:0] eff_len(input logic [15:0] len);
		eff_len = (len == 16'd0) ? 16'd1 : len;
	endfunction

	function automatic logic [15:0] sat_sub(input logic [15:0] a, input logic [15:0] b);
		sat_sub = (a >= b) ? (a - b) : 16'd0;
	endfunction

endpackage

### design/azsg_cfg.sv
module azsg_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [azsg_pkg::PADDR_W-1:0]    paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	output azsg_pkg::cfg_t                  cfg,
	output azsg_pkg::cfg_evt_t              evt
);

	azsg_pkg::cfg_t     cfg_q;
	azsg_pkg::reg_idx_t idx;
	logic               wr;
	logic               len_pend_q;

	assign pready = 1'b1;
	assign idx    = azsg_pkg::reg_idx_t'(paddr[azsg_pkg::PADDR_W-1:2]);
	assign wr     = psel && penable && pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_angle     <= azsg_pkg::MIN_ANGLE_RST;
			cfg_q.max_angle     <= azsg_pkg::MAX_ANGLE_RST;
			cfg_q.min_extension <= azsg_pkg::MIN_EXTENSION_RST;
			cfg_q.settle_ticks  <= azsg_pkg::SETTLE_TICKS_RST;
			cfg_q.cycle_length  <= azsg_pkg::CYCLE_LENGTH_RST;
			cfg_q.shrink_step   <= azsg_pkg::SHRINK_STEP_RST;
			cfg_q.row_step      <= azsg_pkg::ROW_STEP_RST;
			cfg_q.angle_step    <= azsg_pkg::ANGLE_STEP_RST;
			len_pend_q          <= 1'b0;
		end else begin
			len_pend_q <= wr && (idx == azsg_pkg::REG_CYCLE_LENGTH);
			if (wr) begin
				unique case (idx)
					azsg_pkg::REG_MIN_ANGLE:     cfg_q.min_angle     <= pwdata[15:0];
					azsg_pkg::REG_MAX_ANGLE:     cfg_q.max_angle     <= pwdata[15:0];
					azsg_pkg::REG_MIN_EXTENSION: cfg_q.min_extension <= pwdata[15:0];
					azsg_pkg::REG_SETTLE_TICKS:  cfg_q.settle_ticks  <= pwdata[15:0];
					azsg_pkg::REG_CYCLE_LENGTH:  cfg_q.cycle_length  <= pwdata[15:0];
					azsg_pkg::REG_SHRINK_STEP:   cfg_q.shrink_step   <= pwdata[15:0];
					azsg_pkg::REG_ROW_STEP:      cfg_q.row_step      <= pwdata[15:0];
					azsg_pkg::REG_ANGLE_STEP:    cfg_q.angle_step    <= pwdata[14:0];
					default: ;
				endcase
			end
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			azsg_pkg::REG_MIN_ANGLE:     prdata = {16'd0, cfg_q.min_angle};
			azsg_pkg::REG_MAX_ANGLE:     prdata = {16'd0, cfg_q.max_angle};
			azsg_pkg::REG_MIN_EXTENSION: prdata = {16'd0, cfg_q.min_extension};
			azsg_pkg::REG_SETTLE_TICKS:  prdata = {16'd0, cfg_q.settle_ticks};
			azsg_pkg::REG_CYCLE_LENGTH:  prdata = {16'd0, cfg_q.cycle_length};
			azsg_pkg::REG_SHRINK_STEP:   prdata = {16'd0, cfg_q.shrink_step};
			azsg_pkg::REG_ROW_STEP:      prdata = {16'd0, cfg_q.row_step};
			azsg_pkg::REG_ANGLE_STEP:    prdata = {17'd0, cfg_q.angle_step};
			default:                     prdata = 32'd0;
		endcase
	end

	assign cfg          = cfg_q;
	assign evt.wr_len   = wr && (idx == azsg_pkg::REG_CYCLE_LENGTH);
	assign evt.len_pend = len_pend_q;

endmodule

### design/azsg_rem.sv
module azsg_rem (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [16:0]            dividend,
	input  logic [15:0]            divisor,
	output azsg_pkg::rem_stat_t    stat
);

	logic [16:0]                     dvd_q;
	logic [15:0]                     div_q;
	logic [15:0]                     rem_q;
	logic [azsg_pkg::REM_CNT_W-1:0]  cnt_q;
	logic                            busy_q;
	logic [16:0]                     trial;
	logic [15:0]                     rem_nxt;
	logic                            last;

	// restoring step: shift in one dividend bit, subtract if it fits
	assign trial   = {rem_q, dvd_q[16]};
	assign rem_nxt = (trial >= {1'b0, div_q}) ? 16'(trial - {1'b0, div_q}) : trial[15:0];
	assign last    = (cnt_q == azsg_pkg::REM_CNT_W'(azsg_pkg::REM_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (last)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[15:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign stat.busy  = busy_q;
	assign stat.done  = busy_q && last;
	assign stat.value = rem_nxt;

endmodule

### design/azsg_sweep.sv
module azsg_sweep (
	input  logic                   clk,
	input  logic                   arst_n,
	input  azsg_pkg::cfg_t         cfg,
	input  logic                   fire,
	input  azsg_pkg::item_t        item,
	input  azsg_pkg::rem_stat_t    rem,
	output logic [15:0]            tick,
	output azsg_pkg::result_t      result
);

	// sweep state
	logic signed [15:0] angle_q,   angle_d;
	logic        [15:0] ext_q,     ext_d;
	logic        [15:0] tgt_ext_q, tgt_ext_d;
	logic               cw_q,      cw_d;
	logic               short_q,   short_d;
	logic               active_q,  active_d;
	logic        [15:0] tick_q,    tick_d;
	// (tick_q + 1) mod length, kept ready for the next tick
	logic        [15:0] wrap_q,    wrap_d;

	logic        [15:0] len;
	logic        [16:0] wrap_inc;
	logic signed [16:0] ang_sum;
	logic signed [15:0] ang_sat;
	logic               hold;
	logic               gated;
	logic               done_cond;
	logic               rev_cond;

	assign len      = azsg_pkg::eff_len(cfg.cycle_length);
	assign gated    = tick_q >= cfg.settle_ticks;

	// angle step with saturation
	always_comb begin
		if (cw_q)
			ang_sum = 17'(angle_q) + $signed({2'b00, cfg.angle_step});
		else
			ang_sum = 17'(angle_q) - $signed({2'b00, cfg.angle_step});
		if (ang_sum > 17'sd32767)
			ang_sat = 16'sh7fff;
		else if (ang_sum < -17'sd32768)
			ang_sat = 16'sh8000;
		else
			ang_sat = ang_sum[15:0];
	end

	assign done_cond = (ext_q < cfg.min_extension) ||
		((angle_q == cfg.min_angle) && !cw_q && (ext_q <= cfg.min_extension));
	assign rev_cond  = (!cw_q && (angle_q <= cfg.min_angle)) ||
		(cw_q && (angle_q >= cfg.max_angle));
	assign wrap_inc  = {1'b0, wrap_q} + 17'd1;

	// next state for one item
	always_comb begin
		angle_d    = angle_q;
		ext_d      = ext_q;
		tgt_ext_d  = tgt_ext_q;
		cw_d       = cw_q;
		short_d    = short_q;
		active_d   = active_q;
		tick_d     = tick_q;
		wrap_d     = wrap_q;
		hold       = 1'b1;
		if (item.op == azsg_pkg::OP_START) begin
			angle_d    = item.start_angle;
			ext_d      = item.start_extension;
			cw_d       = item.start_clockwise;
			active_d   = 1'b1;
			short_d    = 1'b0;
			tgt_ext_d  = '0;
			tick_d     = '0;
			wrap_d     = (len == 16'd1) ? 16'd0 : 16'd1;
		end else if (active_q) begin
			if (gated) begin
				priority if (done_cond) begin
					active_d = 1'b0;
				end else if (short_q) begin
					if (ext_q >= tgt_ext_q)
						ext_d = azsg_pkg::sat_sub(ext_q, cfg.shrink_step);
					else
						short_d = 1'b0;
				end else if (rev_cond) begin
					hold       = 1'b0;
					cw_d       = !cw_q;
					tgt_ext_d  = azsg_pkg::sat_sub(ext_q, cfg.row_step);
					short_d    = 1'b1;
				end else begin
					hold    = 1'b0;
					angle_d = ang_sat;
				end
			end
			// counter wrap; wrap_q is already below len
			tick_d = wrap_q;
			wrap_d = (wrap_inc == {1'b0, len}) ? 16'd0 : wrap_inc[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q    <= '0;
			ext_q      <= '0;
			tgt_ext_q  <= '0;
			cw_q       <= 1'b0;
			short_q    <= 1'b0;
			active_q   <= 1'b0;
			tick_q     <= '0;
			wrap_q     <= '0;
		end else if (fire) begin
			angle_q    <= angle_d;
			ext_q      <= ext_d;
			tgt_ext_q  <= tgt_ext_d;
			cw_q       <= cw_d;
			short_q    <= short_d;
			active_q   <= active_d;
			tick_q     <= tick_d;
			wrap_q     <= wrap_d;
		end else if (rem.done) begin
			// new cycle length: re-reduce the pending wrap value
			wrap_q <= rem.value;
		end
	end

	assign tick                  = tick_q;
	assign result.angle_command  = angle_d;
	assign result.ext_cmd        = ext_d;
	assign result.hold_flag      = hold;
	assign result.running        = active_d;

endmodule

### design/angular_zigzag_sweep_generator_core.sv
// An accepted item passes the input register, then the result register, before its result word is valid.
// Throughput: one item per cycle while the result side keeps up.
// A write to cycle_length stalls item intake while a bit-serial
// remainder unit re-reduces the tick counter wrap value (17 steps plus setup).
// Reset (arst_n low, async): registers to defaults, scan idle, state zero, no words.
module angular_zigzag_sweep_generator_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  azsg_pkg::item_t                 item,
	output logic                            res_valid,
	input  logic                            res_ready,
	output azsg_pkg::result_t               res,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [azsg_pkg::PADDR_W-1:0]    paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	`include "angular_zigzag_sweep_generator_core_macros.svh"

	azsg_pkg::cfg_t      cfg;
	azsg_pkg::cfg_evt_t  evt;
	azsg_pkg::rem_stat_t rem;
	azsg_pkg::item_t     item_s1;
	azsg_pkg::result_t   res_s2;
	azsg_pkg::result_t   res_d;
	logic                valid_s1;
	logic                valid_s2;
	logic                hold_off;
	logic                fire;
	logic [15:0]         tick;

	azsg_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.evt     (evt)
	);

	azsg_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (evt.len_pend),
		.dividend ({1'b0, tick} + 17'd1),
		.divisor  (azsg_pkg::eff_len(cfg.cycle_length)),
		.stat     (rem)
	);

	azsg_sweep u_sweep (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.fire   (fire),
		.item   (item_s1),
		.rem    (rem),
		.tick   (tick),
		.result (res_d)
	);

	// handshake: stall on a cycle_length write and while the wrap value is being re-reduced
	assign hold_off   = rem.busy || evt.len_pend || evt.wr_len;
	assign fire       = valid_s1 && (!valid_s2 || res_ready) && !hold_off;
	assign item_ready = (!valid_s1 || fire) && !hold_off;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (item_valid && item_ready)
			valid_s1 <= 1'b1;
		else if (fire)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready)
			item_s1 <= item;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (fire)
			valid_s2 <= 1'b1;
		else if (res_ready)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fire)
			res_s2 <= res_d;
	end

	assign res_valid = valid_s2;
	assign res       = res_s2;

	// checks
	`AZSG_ASSERT_NEXT(a_fire_shows_word, clk, arst_n, fire, res_valid)
	`AZSG_ASSERT_SAME(a_no_intake_in_reduce, clk, arst_n, rem.busy, !item_ready && !fire)
	`AZSG_ASSERT_NEXT(a_start_runs, clk, arst_n,
		fire && (item_s1.op == azsg_pkg::OP_START), res.running && res.hold_flag)

endmodule

### tb/sv/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import azsg_pkg::*;

	localparam int STALL_LIMIT = 2000;

	// Scoreboard: tracks the sweep state and queues one command word per item
	class sweep_checker;
		// register copies
		int min_ang, max_ang, min_ext, settle, cyc_len, shrink, row, astep;
		// scan state
		int ang, ext, tgt_ext, tick_cnt;
		bit cw, shortening, active;
		result_t pending_cmds[$];
		int errors, checked, n_items, n_starts, n_reversals, n_completions, n_saturations;

		function new();
			min_ang = int'(MIN_ANGLE_RST);
			max_ang = int'(MAX_ANGLE_RST);
			min_ext = int'(MIN_EXTENSION_RST);
			settle = int'(SETTLE_TICKS_RST);
			cyc_len = int'(CYCLE_LENGTH_RST);
			shrink = int'(SHRINK_STEP_RST);
			row = int'(ROW_STEP_RST);
			astep = int'(ANGLE_STEP_RST);
			ang = 0;
			ext = 0;
			tgt_ext = 0;
			tick_cnt = 0;
			cw = 0;
			shortening = 0;
			active = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [31:0] v);
			case (idx)
				REG_MIN_ANGLE: min_ang = int'($signed(v[15:0]));
				REG_MAX_ANGLE: max_ang = int'($signed(v[15:0]));
				REG_MIN_EXTENSION: min_ext = int'(v[15:0]);
				REG_SETTLE_TICKS: settle = int'(v[15:0]);
				REG_CYCLE_LENGTH: cyc_len = int'(v[15:0]);
				REG_SHRINK_STEP: shrink = int'(v[15:0]);
				REG_ROW_STEP: row = int'(v[15:0]);
				REG_ANGLE_STEP: astep = int'(v[14:0]);
				default: ;
			endcase
		endfunction

		// advance the sweep by one accepted item and queue the command it yields
		function void take_item(item_t it);
			bit hold;
			int d_min, d_max, a, m;
			result_t r;
			hold = 1'b1;
			n_items++;
			if (it.op == OP_START) begin
				ang = int'($signed(it.start_angle));
				ext = int'(it.start_extension);
				cw = it.start_clockwise;
				active = 1'b1;
				shortening = 1'b0;
				tgt_ext = 0;
				tick_cnt = 0;
				n_starts++;
			end else if (active) begin
				// gated tick: complete, shorten, reverse or step
				if (tick_cnt >= settle) begin
					d_min = ang - min_ang;
					d_max = max_ang - ang;
					hold = 1'b0;
					if ((d_min == 0 && !cw && ext <= min_ext) || ext < min_ext) begin
						hold = 1'b1;
						active = 1'b0;
						n_completions++;
					end else if (shortening) begin
						hold = 1'b1;
						if (ext >= tgt_ext)
							ext = (ext >= shrink) ? ext - shrink : 0;
						else
							shortening = 1'b0;
					end else if ((d_min <= 0 && !cw) || (d_max <= 0 && cw)) begin
						cw = !cw;
						tgt_ext = (ext >= row) ? ext - row : 0;
						shortening = 1'b1;
						n_reversals++;
					end else begin
						a = cw ? ang + astep : ang - astep;
						if (a > 32767) begin
							a = 32767;
							n_saturations++;
						end else if (a < -32768) begin
							a = -32768;
							n_saturations++;
						end
						ang = a;
					end
				end
				// zero length behaves as one
				m = (cyc_len == 0) ? 1 : cyc_len;
				tick_cnt = (tick_cnt + 1) % m;
			end
			r.angle_command = ang[15:0];
			r.ext_cmd = ext[15:0];
			r.hold_flag = hold;
			r.running = active;
			pending_cmds = {pending_cmds, r};
		endfunction

		function void check_command(result_t got);
			result_t want;
			if (pending_cmds.size() == 0) begin
				$display("%0t: result word with nothing pending, actual %p", $time, got);
				errors++;
				return;
			end
			want = pending_cmds.pop_front();
			checked++;
			if (got.angle_command !== want.angle_command) begin
				$display("%0t: angle_command expected %0d, actual %0d", $time,
					$signed(want.angle_command), $signed(got.angle_command));
				errors++;
			end
			if (got.ext_cmd !== want.ext_cmd) begin
				$display("%0t: ext_cmd expected %0d, actual %0d", $time,
					want.ext_cmd, got.ext_cmd);
				errors++;
			end
			if (got.hold_flag !== want.hold_flag) begin
				$display("%0t: hold_flag expected %0b, actual %0b", $time,
					want.hold_flag, got.hold_flag);
				errors++;
			end
			if (got.running !== want.running) begin
				$display("%0t: running expected %0b, actual %0b", $time,
					want.running, got.running);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	item_t item = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	result_t res;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	sweep_checker sb;
	bit no_gaps = 1'b0;
	int n_settings = 0;
	int stall_cycles = 0;

	angular_zigzag_sweep_generator_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic bit take_gap();
		return !no_gaps && ($urandom_range(99) < 7);
	endfunction

	// result side back-pressure
	always @(negedge clk) begin
		res_ready <= !take_gap();
	end

	// handshake monitors and stall watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready || res_valid && res_ready ||
					psel && penable && pwrite && pready)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (item_valid && item_ready)
				sb.take_item(item);
			if (res_valid && res_ready)
				sb.check_command(res);
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, stall_cycles);
				$display("angular_zigzag_sweep_generator_core test failed");
				$finish;
			end
		end
	end

	// all tasks start and end just after a falling edge
	task automatic send_item(item_t it);
		while (take_gap()) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!item_ready);
		@(negedge clk);
	endtask

	task automatic apb_write(reg_idx_t idx, logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, v);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	// wait for every pending word, then idle past the pipeline depth
	task automatic drain();
		item_valid <= 1'b0;
		while (sb.pending_cmds.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic item_t mk_start(int a, int e, bit dir);
		item_t t;
		t.op = OP_START;
		t.start_angle = 16'(a);
		t.start_extension = 16'(e);
		t.start_clockwise = dir;
		return t;
	endfunction

	// tick with junk in the unused fields
	function automatic item_t rand_tick();
		item_t t;
		t.op = OP_TICK;
		t.start_angle = 16'($urandom);
		t.start_extension = 16'($urandom);
		t.start_clockwise = 1'($urandom);
		return t;
	endfunction

	// sane starts land inside the bounds, with up to three rows of extension (plus 50) above the minimum
	function automatic item_t rand_start(bit sane);
		int lo, hi, e;
		if (!sane)
			return mk_start(int'($urandom), int'($urandom), 1'($urandom));
		lo = (sb.min_ang < sb.max_ang) ? sb.min_ang : sb.max_ang;
		hi = (sb.min_ang < sb.max_ang) ? sb.max_ang : sb.min_ang;
		e = sb.min_ext + int'($urandom_range(3 * sb.row + 50));
		if (e > 65535)
			e = 65535;
		return mk_start(lo + int'($urandom_range(hi - lo)), e, 1'($urandom));
	endfunction

	task automatic run_random(int n);
		item_t it;
		for (int i = 0; i < n; i++) begin
			if ((!sb.active && $urandom_range(3) == 0) || $urandom_range(49) == 0)
				it = rand_start($urandom_range(9) < 7);
			else
				it = rand_tick();
			send_item(it);
		end
	endtask

	task automatic load_settings(cfg_t c);
		drain();
		apb_write(REG_MIN_ANGLE, {16'h0, c.min_angle});
		apb_write(REG_MAX_ANGLE, {16'h0, c.max_angle});
		apb_write(REG_MIN_EXTENSION, {16'h0, c.min_extension});
		apb_write(REG_SETTLE_TICKS, {16'h0, c.settle_ticks});
		apb_write(REG_CYCLE_LENGTH, {16'h0, c.cycle_length});
		apb_write(REG_SHRINK_STEP, {16'h0, c.shrink_step});
		apb_write(REG_ROW_STEP, {16'h0, c.row_step});
		apb_write(REG_ANGLE_STEP, {17'h0, c.angle_step});
		n_settings++;
	endtask

	task automatic run_phase(cfg_t c, int n, bit steady);
		load_settings(c);
		no_gaps = steady;
		run_random(n);
		no_gaps = 1'b0;
	endtask

	initial begin
		sb = new();
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, reset settings: idle ticks, a start, a start that ends at once
		send_item(mk_start(-1, 65535, 1'b1) ^ 34'h2_0000_0000);
		send_item(mk_start(0, 0, 1'b0) ^ 34'h2_0000_0000);
		send_item(mk_start(0, 20000, 1'b1));
		send_item(rand_tick());
		send_item(rand_tick());
		send_item(mk_start(-32768, 0, 1'b0));
		send_item(rand_tick());
		send_item(rand_tick());

		// directed, tight bounds: step, reverse, shorten, extremes, completion
		load_settings('{-16'sd100, 16'sd100, 16'd1000, 16'd0, 16'd1, 16'd200, 16'd300, 15'd60});
		send_item(mk_start(0, 1500, 1'b1));
		repeat (10) send_item(rand_tick());
		send_item(mk_start(32767, 65535, 1'b1));
		send_item(rand_tick());
		send_item(mk_start(-32768, 999, 1'b0));
		send_item(rand_tick());
		send_item(rand_tick());

		// random phases over a spread of settings
		run_phase('{-16'sd200, 16'sd200, 16'd2000, 16'd0, 16'd1, 16'd100, 16'd500, 15'd50},
			400, 1'b0);
		run_phase('{-16'sd32768, 16'sd32767, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			15'h7FFF}, 250, 1'b0);
		run_phase('{16'sd0, 16'sd300, 16'd6554, 16'd3, 16'd5, 16'd66, 16'd655, 15'd41},
			300, 1'b1);
		run_phase('{16'sd100, 16'sd100, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 15'd1},
			150, 1'b0);
		run_phase('{16'sd0, 16'sd500, 16'd100, 16'hFFFF, 16'd0, 16'd10, 16'd20, 15'd5},
			60, 1'b0);
		run_phase('{16'sd500, -16'sd500, 16'd1000, 16'd0, 16'd3, 16'd300, 16'd200, 15'd7},
			250, 1'b0);
		run_phase('{-16'sd32000, 16'sd32700, 16'd300, 16'd1, 16'd2, 16'd1, 16'd3,
			15'd20000}, 300, 1'b0);
		run_phase('{16'sd0, 16'sd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 15'd0}, 100, 1'b0);

		drain();
		repeat (8) @(negedge clk);
		$display("Ran %0d items (%0d starts) across %0d register settings; %0d words checked.",
			sb.n_items, sb.n_starts, n_settings, sb.checked);
		$display("Sweep events: %0d reversals, %0d completions, %0d saturated steps.",
			sb.n_reversals, sb.n_completions, sb.n_saturations);
		if (sb.errors == 0 && sb.pending_cmds.size() == 0)
			$display("angular_zigzag_sweep_generator_core test passed");
		else
			$display("angular_zigzag_sweep_generator_core test failed");
		$finish;
	end

endmodule
